// ===== rtl/ldas_pkg.sv =====
package ldas_pkg;

	localparam int VAL_W     = 16;
	localparam int IDX_W     = 4;
	localparam int SUM_W     = 37;
	localparam int SQ_W      = 33;
	localparam int ACT_W     = 8;
	localparam int GOALS_DEF = 16;
	localparam int ACTIONS   = 256;

	localparam logic [ACT_W-1:0] IDX_MAX =
		ACT_W'(((ACTIONS - 1) < 255) ? (ACTIONS - 1) : 255);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic valid;
		logic last_goal;
		logic last_action;
	} ctrl_t;

endpackage

// ===== rtl/least_discontent_action_select.sv =====
// A result shows on result_valid after the word closing a decision passes the insistence
// memory read, add and square registers and the result register. One word per cycle
// while item_stall is low; add, square and accumulate form a 3-stage pipeline after the read.
// The input stalls only while a finished result is held and another is ready to close.
// Reset (arst_n low) clears pipeline control and decision state, not the insistence memory.
module least_discontent_action_select import ldas_pkg::*; #(
	parameter int GOALS = GOALS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    op,
	input  logic [IDX_W-1:0]        goal_index,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_goal,
	input  logic                    last_action,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [ACT_W-1:0]        best_action,
	output logic [SUM_W-1:0]        best_score
);

	logic                    en, accept, in_range;
	logic signed [VAL_W-1:0] rdata;
	ctrl_t                   ctrl_s0, ctrl_s3;
	logic [SQ_W-1:0]         sq;

	assign accept     = item_valid && en;
	assign item_stall = !en;

	assign ctrl_s0.valid       = accept && op;
	assign ctrl_s0.last_goal   = last_goal;
	assign ctrl_s0.last_action = last_action;

	ldas_insist_mem #(.GOALS(GOALS)) u_mem (
		.clk        (clk),
		.en         (en),
		.wr         (accept && !op),
		.goal_index (goal_index),
		.wdata      (value),
		.in_range   (in_range),
		.rdata      (rdata)
	);

	ldas_square u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (ctrl_s0),
		.value    (value),
		.in_range (in_range),
		.rdata    (rdata),
		.ctrl_out (ctrl_s3),
		.sq       (sq)
	);

	ldas_select u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl_s3),
		.sq           (sq),
		.en           (en),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.best_action  (best_action),
		.best_score   (best_score)
	);

endmodule

// ===== rtl/ldas_insist_mem.sv =====
module ldas_insist_mem import ldas_pkg::*; #(
	parameter int GOALS = GOALS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    wr,
	input  logic [IDX_W-1:0]        goal_index,
	input  logic signed [VAL_W-1:0] wdata,
	output logic                    in_range,
	output logic signed [VAL_W-1:0] rdata
);

	localparam int GW = (GOALS > 1) ? $clog2(GOALS) : 1;

	logic signed [VAL_W-1:0] mem [GOALS];
	logic [GW-1:0]           addr;

	assign addr     = GW'(goal_index);
	assign in_range = int'(goal_index) < GOALS;

	always_ff @(posedge clk) begin
		if (wr && in_range) begin
			mem[addr] <= wdata;
		end
		if (en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/ldas_square.sv =====
module ldas_square import ldas_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ctrl_t                   ctrl_in,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    in_range,
	input  logic signed [VAL_W-1:0] rdata,
	output ctrl_t                   ctrl_out,
	output logic [SQ_W-1:0]         sq
);

	ctrl_t                   ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [VAL_W-1:0] value_s1;
	logic                    inr_s1;
	logic signed [VAL_W-1:0] ins;
	logic signed [VAL_W:0]   sum_s2;
	logic signed [2*VAL_W+1:0] prod;
	logic [SQ_W-1:0]         sq_s3;

	assign ins  = inr_s1 ? rdata : '0;
	assign prod = sum_s2 * sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s1 <= value;
			inr_s1   <= in_range;
			sum_s2   <= {ins[VAL_W-1], ins} + {value_s1[VAL_W-1], value_s1};
			sq_s3    <= prod[SQ_W-1:0];
		end
	end

	assign ctrl_out = ctrl_s3;
	assign sq       = sq_s3;

endmodule

// ===== rtl/ldas_select.sv =====
module ldas_select import ldas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_t            ctrl,
	input  logic [SQ_W-1:0]  sq,
	output logic             en,
	input  logic             result_stall,
	output logic             result_valid,
	output logic [ACT_W-1:0] best_action,
	output logic [SUM_W-1:0] best_score
);

	logic [SUM_W-1:0] run_q, best_q;
	logic [ACT_W-1:0] cnt_q, best_idx_q;
	logic             have_q;
	logic             valid_q;
	logic [ACT_W-1:0] action_q;
	logic [SUM_W-1:0] score_q;

	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] run_new, best_new;
	logic [ACT_W-1:0] idx_new;
	logic             better, fire;

	assign sum_wide = {1'b0, run_q} + (SUM_W+1)'(sq);
	assign run_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
	assign better   = !have_q || (run_new < best_q);
	assign best_new = better ? run_new : best_q;
	assign idx_new  = better ? cnt_q : best_idx_q;
	assign fire     = ctrl.valid && ctrl.last_goal && ctrl.last_action;
	assign en       = !(valid_q && result_stall && fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			cnt_q      <= '0;
			have_q     <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (en && fire) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
			if (en && ctrl.valid) begin
				if (!ctrl.last_goal) begin
					run_q <= run_new;
				end else if (ctrl.last_action) begin
					run_q      <= '0;
					best_q     <= '0;
					best_idx_q <= '0;
					cnt_q      <= '0;
					have_q     <= 1'b0;
				end else begin
					run_q      <= '0;
					best_q     <= best_new;
					best_idx_q <= idx_new;
					have_q     <= 1'b1;
					if (cnt_q < IDX_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && fire) begin
			action_q <= idx_new;
			score_q  <= best_new;
		end
	end

	assign result_valid = valid_q;
	assign best_action  = action_q;
	assign best_score   = score_q;

`ifndef NO_ASSERTIONS
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (cnt_q == '0 && best_q == '0 && best_idx_q == '0))
		else $error("decision state not clear without a best action");
	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		best_idx_q <= cnt_q)
		else $error("best index ahead of action counter");
	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (valid_q && fire))
		else $error("pipeline held without a blocked result");
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fire) |=> valid_q)
		else $error("closing word gave no result");
`endif

endmodule
